// ===== rtl/bslf_pkg.sv =====
// ----------------------------------------------------------------------------
// bslf_pkg: shared definitions for the status LED and button controller
// Holds the counter width, the register map, the reset values of the
// registers and the codes for mode, blink phase and LED color.
// ----------------------------------------------------------------------------
package bslf_pkg;

  localparam int TICK_BITS = 16;
  localparam int CFG_BITS  = 16;
  localparam int IDX_BITS  = 2;

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [CFG_BITS-1:0]  cfg_word_t;

  localparam logic [IDX_BITS-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_BLINK_ON   = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_BLINK_OFF  = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_IDLE_GAP   = 2'd3;

  localparam cfg_word_t LONG_PRESS_RST = 16'd100;
  localparam cfg_word_t BLINK_ON_RST   = 16'd25;
  localparam cfg_word_t BLINK_OFF_RST  = 16'd25;
  localparam cfg_word_t IDLE_GAP_RST   = 16'd100;

  typedef enum logic [1:0] {
    MODE_STARTUP = 2'd0,
    MODE_RUN     = 2'd1,
    MODE_FAULT   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_SOLID = 2'd0,
    PH_ON    = 2'd1,
    PH_OFF   = 2'd2,
    PH_IDLE  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    LED_OFF = 2'd0,
    LED_RED = 2'd1,
    LED_YEL = 2'd2,
    LED_GRN = 2'd3
  } color_t;

  // Press events from the debouncer, before the run-mode qualification.
  typedef struct packed {
    logic short_hit;
    logic long_hit;
  } press_t;

  // Brings a 16-bit register value to the counter width.
  function automatic tick_t to_tick(cfg_word_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[TICK_BITS-1:0];
  endfunction

endpackage

// ===== rtl/bslf_press.sv =====
// ----------------------------------------------------------------------------
// bslf_press: two-sample button debouncer with long-press countdown
// Advances once per accepted item and reports the raw short and long press
// events of that item.
// ----------------------------------------------------------------------------
module bslf_press (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                button,
  input  bslf_pkg::cfg_word_t long_press_ticks,
  output bslf_pkg::press_t    press
);
  import bslf_pkg::*;

  logic  prev_r, prev_nxt;
  logic  held_r, held_nxt;
  tick_t cnt_r, cnt_nxt;

  always_comb begin
    logic released;
    released = 1'b0;
    held_nxt = held_r;
    cnt_nxt  = cnt_r;
    press    = '0;
    if (button && prev_r && !held_r) begin
      held_nxt = 1'b1;
      cnt_nxt  = to_tick(long_press_ticks);
    end
    if (!button && !prev_r && held_r) begin
      held_nxt = 1'b0;
      released = 1'b1;
    end
    prev_nxt = button;
    if (held_nxt && cnt_nxt != '0) begin
      cnt_nxt = cnt_nxt - 1'b1;
      if (cnt_nxt == '0) begin
        press.long_hit = 1'b1;
      end
    end
    // A release counts as short only if the countdown never ran out.
    press.short_hit = released && (cnt_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      held_r <= 1'b0;
      cnt_r  <= '0;
    end else if (advance) begin
      prev_r <= prev_nxt;
      held_r <= held_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/button_status_led_fault_blinker_core.sv =====
// ----------------------------------------------------------------------------
// button_status_led_fault_blinker_core: status LED, fault blink codes, button
//
//   Channel  Direction  Contents
//   in_      slave      one tick: button, startup done, fault write and code
//   out_     master     one result per tick: LED color, presses, mode
//   cfg_     write      press and blink timing registers 0..3
//
// One item per clock cycle; each result appears in the output register in the
// cycle after its item is accepted. All per-tick work is a few 16-bit
// decrements and compares between the state registers and the output
// register. The input is ready whenever the output register is empty or
// being taken, so a stalled output stops intake only while a result waits.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_status_led_fault_blinker_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [0] button_level, [1] startup_done, [2] fault_write, [6:3] fault_code
  input  logic [7:0]                    in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] led_color, [2] short_press, [3] long_press, [5:4] mode
  output logic [7:0]                    out_tdata,
  input  logic                          cfg_we,
  input  logic [bslf_pkg::IDX_BITS-1:0] cfg_index,
  input  bslf_pkg::cfg_word_t           cfg_wdata
);
  import bslf_pkg::*;

  cfg_word_t long_press_r, blink_on_r, blink_off_r, idle_gap_r;

  mode_t     mode_r, mode_nxt;
  mode_t     saved_r, saved_nxt;
  phase_t    phase_r, phase_nxt;
  tick_t     bcnt_r, bcnt_nxt;
  logic [3:0] left_r, left_nxt;
  logic [3:0] fault_r, fault_nxt;
  color_t    color_r, color_nxt;

  logic      out_valid_r;
  color_t    res_color_r;
  logic      res_short_r, res_long_r;
  mode_t     res_mode_r;

  press_t    press;
  logic      in_fire;
  logic      btn, sdone, fwr;
  logic [3:0] code;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign btn       = in_tdata[0];
  assign sdone     = in_tdata[1];
  assign fwr       = in_tdata[2];
  assign code      = in_tdata[6:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RST;
      blink_on_r   <= BLINK_ON_RST;
      blink_off_r  <= BLINK_OFF_RST;
      idle_gap_r   <= IDLE_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_PRESS: long_press_r <= cfg_wdata;
        REG_BLINK_ON:   blink_on_r   <= cfg_wdata;
        REG_BLINK_OFF:  blink_off_r  <= cfg_wdata;
        REG_IDLE_GAP:   idle_gap_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bslf_press u_press (
    .clk              (clk),
    .rst_n            (rst_n),
    .advance          (in_fire),
    .button           (btn),
    .long_press_ticks (long_press_r),
    .press            (press)
  );

  always_comb begin
    mode_t enter;
    logic  do_enter;
    mode_nxt  = mode_r;
    saved_nxt = saved_r;
    phase_nxt = phase_r;
    bcnt_nxt  = bcnt_r;
    left_nxt  = left_r;
    fault_nxt = fault_r;
    color_nxt = color_r;
    enter     = MODE_RUN;
    do_enter  = 1'b0;

    if (sdone && mode_r != MODE_FAULT) begin
      do_enter = 1'b1;
      enter    = MODE_RUN;
    end
    // A fault write comes after startup done, so it overrides the target.
    if (fwr) begin
      fault_nxt = code;
      do_enter  = 1'b1;
      if (code == 4'd0) begin
        enter = saved_r;
      end else begin
        if (mode_r != MODE_FAULT && !(sdone && mode_r != MODE_FAULT)) begin
          saved_nxt = mode_r;
        end else if (mode_r != MODE_FAULT) begin
          saved_nxt = MODE_RUN;
        end
        enter = MODE_FAULT;
      end
    end

    if (do_enter) begin
      unique case (enter)
        MODE_RUN: begin
          mode_nxt  = MODE_RUN;
          color_nxt = LED_GRN;
          phase_nxt = PH_SOLID;
        end
        MODE_FAULT: begin
          mode_nxt = MODE_FAULT;
          if (fault_nxt != 4'd0) begin
            left_nxt  = fault_nxt;
            phase_nxt = PH_ON;
            bcnt_nxt  = to_tick(blink_on_r);
            color_nxt = LED_RED;
          end
        end
        default: begin
          mode_nxt  = MODE_STARTUP;
          color_nxt = LED_YEL;
          phase_nxt = PH_SOLID;
        end
      endcase
    end

    // Blink sequencer ticks in the same cycle a sequence starts.
    if (phase_nxt != PH_SOLID) begin
      bcnt_nxt = bcnt_nxt - 1'b1;
      if (bcnt_nxt == '0) begin
        case (phase_nxt)
          PH_ON: begin
            phase_nxt = PH_OFF;
            bcnt_nxt  = to_tick(blink_off_r);
            color_nxt = LED_OFF;
          end
          PH_OFF: begin
            left_nxt = left_nxt - 4'd1;
            if (left_nxt == 4'd0) begin
              phase_nxt = PH_IDLE;
              bcnt_nxt  = to_tick(idle_gap_r);
              color_nxt = LED_OFF;
            end else begin
              phase_nxt = PH_ON;
              bcnt_nxt  = to_tick(blink_on_r);
              color_nxt = LED_RED;
            end
          end
          default: begin
            left_nxt  = fault_nxt;
            phase_nxt = PH_ON;
            bcnt_nxt  = to_tick(blink_on_r);
            color_nxt = LED_RED;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_STARTUP;
      saved_r <= MODE_STARTUP;
      phase_r <= PH_SOLID;
      bcnt_r  <= '0;
      left_r  <= 4'd0;
      fault_r <= 4'd0;
      color_r <= LED_YEL;
    end else if (in_fire) begin
      mode_r  <= mode_nxt;
      saved_r <= saved_nxt;
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      left_r  <= left_nxt;
      fault_r <= fault_nxt;
      color_r <= color_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_color_r <= color_nxt;
      res_short_r <= press.short_hit && (mode_nxt == MODE_RUN);
      res_long_r  <= press.long_hit && (mode_nxt == MODE_RUN);
      res_mode_r  <= mode_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_mode_r, res_long_r, res_short_r, res_color_r};

endmodule

// ===== tb/tb_button_status_led_fault_blinker_core.sv =====
// ----------------------------------------------------------------------------
// Testbench for button_status_led_fault_blinker_core
// Drives button, startup and fault-code ticks through the input stream and
// checks every result against a predictor of the LED, press and mode logic.
// A directed sequence covers the mode changes and fault-code corners; random
// ticks then run under several timing register settings. Both stream sides
// idle and stall at random.
// ----------------------------------------------------------------------------
import bslf_pkg::*;

class led_status_scoreboard;
  tick_t  long_press_ticks;
  tick_t  blink_on_ticks;
  tick_t  blink_off_ticks;
  tick_t  idle_gap_ticks;

  logic   last_level;
  logic   held;
  tick_t  press_cnt;
  mode_t  mode;
  mode_t  saved_mode;
  phase_t phase;
  tick_t  blink_cnt;
  logic [3:0] blinks_left;
  logic [3:0] fault;
  color_t color;

  // Results not yet seen, packed as on out_tdata.
  logic [7:0] expected_q[$];
  int mismatches;

  function new();
    long_press_ticks = to_tick(LONG_PRESS_RST);
    blink_on_ticks   = to_tick(BLINK_ON_RST);
    blink_off_ticks  = to_tick(BLINK_OFF_RST);
    idle_gap_ticks   = to_tick(IDLE_GAP_RST);
    last_level  = 1'b0;
    held        = 1'b0;
    press_cnt   = '0;
    mode        = MODE_STARTUP;
    saved_mode  = MODE_STARTUP;
    phase       = PH_SOLID;
    blink_cnt   = '0;
    blinks_left = '0;
    fault       = '0;
    color       = LED_YEL;
    mismatches  = 0;
  endfunction

  function void set_register(logic [IDX_BITS-1:0] idx, cfg_word_t val);
    case (idx)
      REG_LONG_PRESS: long_press_ticks = val;
      REG_BLINK_ON:   blink_on_ticks   = val;
      REG_BLINK_OFF:  blink_off_ticks  = val;
      REG_IDLE_GAP:   idle_gap_ticks   = val;
      default: ;
    endcase
  endfunction

  function void start_phase(phase_t ph);
    phase = ph;
    case (ph)
      PH_ON: begin
        blink_cnt = blink_on_ticks;
        color = LED_RED;
      end
      PH_OFF: begin
        blink_cnt = blink_off_ticks;
        color = LED_OFF;
      end
      PH_IDLE: begin
        blink_cnt = idle_gap_ticks;
        color = LED_OFF;
      end
      default: ;
    endcase
  endfunction

  function void switch_mode(mode_t m);
    mode = m;
    if (m == MODE_RUN) begin
      color = LED_GRN;
      phase = PH_SOLID;
    end else if (m == MODE_FAULT) begin
      if (fault != 4'd0) begin
        blinks_left = fault;
        start_phase(PH_ON);
      end
    end else begin
      mode = MODE_STARTUP;
      color = LED_YEL;
      phase = PH_SOLID;
    end
  endfunction

  function void note_tick(logic [7:0] d);
    logic btn, sdone, fwr, released, short_hit, long_hit;
    logic [3:0] code;
    btn   = d[0];
    sdone = d[1];
    fwr   = d[2];
    code  = d[6:3];
    released  = 1'b0;
    short_hit = 1'b0;
    long_hit  = 1'b0;

    if (sdone && mode != MODE_FAULT) switch_mode(MODE_RUN);

    if (fwr) begin
      fault = code;
      if (code == 4'd0) begin
        switch_mode(saved_mode);
      end else begin
        if (mode != MODE_FAULT) saved_mode = mode;
        switch_mode(MODE_FAULT);
      end
    end

    // The blink machine already counts in the tick that starts a sequence.
    case (phase)
      PH_ON: begin
        blink_cnt = blink_cnt - 1'b1;
        if (blink_cnt == '0) start_phase(PH_OFF);
      end
      PH_OFF: begin
        blink_cnt = blink_cnt - 1'b1;
        if (blink_cnt == '0) begin
          blinks_left = blinks_left - 1'b1;
          start_phase(blinks_left == 4'd0 ? PH_IDLE : PH_ON);
        end
      end
      PH_IDLE: begin
        blink_cnt = blink_cnt - 1'b1;
        if (blink_cnt == '0) begin
          blinks_left = fault;
          start_phase(PH_ON);
        end
      end
      default: ;
    endcase

    if (btn && last_level && !held) begin
      held = 1'b1;
      press_cnt = long_press_ticks;
    end
    if (!btn && !last_level && held) begin
      held = 1'b0;
      released = 1'b1;
    end
    last_level = btn;
    if (held && press_cnt != '0) begin
      press_cnt = press_cnt - 1'b1;
      if (press_cnt == '0) long_hit = 1'b1;
    end
    if (released && press_cnt != '0) short_hit = 1'b1;
    if (mode != MODE_RUN) begin
      short_hit = 1'b0;
      long_hit  = 1'b0;
    end

    expected_q.push_back({2'b00, mode, long_hit, short_hit, color});
  endfunction

  function void check_result(logic [7:0] got);
    logic [7:0] want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result %02h with no tick pending", got);
      return;
    end
    want = expected_q.pop_front();
    if (got[1:0] !== want[1:0] || got[2] !== want[2] || got[3] !== want[3] ||
        got[5:4] !== want[5:4]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: color %0d/%0d short %0b/%0b long %0b/%0b mode %0d/%0d",
                 want[1:0], got[1:0], want[2], got[2], want[3], got[3],
                 want[5:4], got[5:4]);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_button_status_led_fault_blinker_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;
  logic                cfg_we = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = '0;
  cfg_word_t           cfg_wdata = '0;

  led_status_scoreboard sb;
  logic in_calm = 1'b0;
  logic out_calm = 1'b0;

  button_status_led_fault_blinker_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] pack_tick(logic btn, logic sdone, logic fwr,
                                           logic [3:0] code);
    return {1'b0, code, fwr, sdone, btn};
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_tvalid still high, so a following item can keep it up.
  task automatic send_item(input logic [7:0] d);
    int gap;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(d);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input cfg_word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_register(idx, val);
    @(negedge clk);
  endtask

  task automatic program_timing(input cfg_word_t lp, input cfg_word_t on_t,
                                input cfg_word_t off_t, input cfg_word_t gap_t);
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_BLINK_ON, on_t);
    write_reg(REG_BLINK_OFF, off_t);
    write_reg(REG_IDLE_GAP, gap_t);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Stops intake and waits until every predicted result has been taken.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Button levels come in held runs so that debounced presses of all
  // lengths occur; single-tick glitches and rare events ride on top.
  task automatic run_random(input int count, input int max_hold);
    int hold_left;
    logic level, btn, sdone, fwr;
    logic [3:0] code;
    hold_left = 0;
    level = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (hold_left == 0) begin
        level = 1'($urandom_range(0, 1));
        hold_left = $urandom_range(1, max_hold);
      end
      hold_left--;
      btn   = level ^ ($urandom_range(0, 15) == 0);
      sdone = ($urandom_range(0, 19) == 0);
      fwr   = ($urandom_range(0, 29) == 0);
      code  = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      send_item(pack_tick(btn, sdone, fwr, code));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] directed[$];
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed = {
      pack_tick(1'b0, 1'b0, 1'b0, 4'd0),
      // A press while starting up is debounced but never reported.
      pack_tick(1'b1, 1'b0, 1'b0, 4'd0), pack_tick(1'b1, 1'b0, 1'b0, 4'd0),
      pack_tick(1'b0, 1'b0, 1'b0, 4'd0), pack_tick(1'b0, 1'b0, 1'b0, 4'd0),
      pack_tick(1'b0, 1'b1, 1'b0, 4'd0),
      pack_tick(1'b1, 1'b0, 1'b0, 4'd0), pack_tick(1'b1, 1'b0, 1'b0, 4'd0),
      pack_tick(1'b1, 1'b0, 1'b0, 4'd0),
      pack_tick(1'b0, 1'b0, 1'b0, 4'd0), pack_tick(1'b0, 1'b0, 1'b0, 4'd0),
      // Clearing while not in fault falls back to the saved startup mode.
      pack_tick(1'b0, 1'b0, 1'b1, 4'd0),
      pack_tick(1'b0, 1'b0, 1'b1, 4'd2), pack_tick(1'b0, 1'b0, 1'b1, 4'd0),
      // Startup done and a fault in the same tick: run is what gets saved.
      pack_tick(1'b1, 1'b1, 1'b1, 4'd15),
      pack_tick(1'b1, 1'b1, 1'b0, 4'd0),
      pack_tick(1'b0, 1'b0, 1'b1, 4'd1), pack_tick(1'b0, 1'b0, 1'b1, 4'd8),
      pack_tick(1'b0, 1'b0, 1'b0, 4'd0),
      pack_tick(1'b0, 1'b0, 1'b1, 4'd0),
      pack_tick(1'b0, 1'b0, 1'b0, 4'd0)
    };
    foreach (directed[i]) send_item(directed[i]);
    settle();

    program_timing(16'd1, 16'd1, 16'd1, 16'd1);
    run_random(460, 6);
    settle();

    program_timing(cfg_word_t'($urandom_range(2, 12)), cfg_word_t'($urandom_range(2, 12)),
                   cfg_word_t'($urandom_range(2, 12)), cfg_word_t'($urandom_range(2, 12)));
    run_random(460, 30);
    settle();

    program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(460, 20);
    settle();

    program_timing(cfg_word_t'($urandom_range(1, 40)), cfg_word_t'($urandom_range(1, 40)),
                   cfg_word_t'($urandom_range(1, 40)), cfg_word_t'($urandom_range(1, 40)));
    run_random(460, 90);
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== button_status_led_fault_blinker_core.f =====
rtl/bslf_pkg.sv
rtl/bslf_press.sv
rtl/button_status_led_fault_blinker_core.sv
tb/tb_button_status_led_fault_blinker_core.sv
